FILE: rtl/vgut_pkg.sv
// Shared types and constants of the bond vector Gram matrix block.
package vgut_pkg;

	localparam int COORD_W = 16;
	localparam int VEC_W   = 3 * COORD_W;
	localparam int IDX_W   = 6;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int DOT_W   = PROD_W + 1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	// one classified vector, queued for the dot product engine
	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [IDX_W-1:0]          col;
		logic                      ovf;
	} cmd_t;

	// command queue status
	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

FILE: rtl/vgut_if.sv
// Valid/ready channel interfaces for bond vectors and Gram matrix results.
interface vgut_bond_if import vgut_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] bond_x;
	logic signed [COORD_W-1:0] bond_y;
	logic signed [COORD_W-1:0] bond_z;
	logic                      last_bond;

	modport source (output valid, bond_x, bond_y, bond_z, last_bond, input ready);
	modport sink (input valid, bond_x, bond_y, bond_z, last_bond, output ready);
endinterface

interface vgut_result_if import vgut_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        row_index;
	logic [IDX_W-1:0]        col_index;
	logic signed [DOT_W-1:0] pair_dot;
	logic                    last_result;
	logic                    overflow;

	modport source (output valid, row_index, col_index, pair_dot, last_result,
		overflow, input ready);
	modport sink (input valid, row_index, col_index, pair_dot, last_result,
		overflow, output ready);
endinterface

FILE: rtl/vector_gram_upper_triangle.sv
// Gram matrix upper triangle of a polymer's bond vectors: top level.
//
// Input channel bond: one bond vector per transfer (x, y, z with 12 fraction
// bits) and last_bond, which ends the polymer. Output channel result: one
// transfer per pair (i, j), i = 0..j, carrying row, column and the exact dot
// product with 24 fraction bits; last_result marks the final pair of a vector.
// A vector arriving with MAX_BONDS vectors already stored gives a single
// result with overflow set and zero fields.
// Vector j gives j + 1 results, one result a cycle while result.ready does not
// stall, set by its single stored-vector read port; an overflow gives one result.
// Each result passes the stage 1, stage 2 and output registers after issue.
// A four-entry command queue lets the front take new vectors while results
// still drain. After a vector with last_bond, the front holds bond.ready low
// until the queue is empty, so the next polymer never overwrites an entry
// that is still to be read.
// Reset clears the vector count, the queue and all valid flags; stored
// vectors are not cleared. When result.ready is low while a result is waiting,
// the engine and its pipeline hold; the queue fills and then bond.ready drops.
module vector_gram_upper_triangle import vgut_pkg::*; #(
	parameter int MAX_BONDS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	vgut_bond_if.sink     bond,
	vgut_result_if.source result
);

	localparam int AW = $clog2(MAX_BONDS);

	fifo_stat_t       q_stat;
	logic             push;
	cmd_t             push_cmd;
	logic             pop;
	cmd_t             head;
	logic             we;
	logic [AW-1:0]    waddr;
	logic [VEC_W-1:0] wdata;
	logic             re;
	logic [AW-1:0]    raddr;
	logic [VEC_W-1:0] rdata;

	vgut_front #(
		.MAX_BONDS(MAX_BONDS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.bond     (bond),
		.q_stat   (q_stat),
		.push     (push),
		.push_cmd (push_cmd),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata)
	);

	vgut_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.stat     (q_stat)
	);

	vgut_ram #(
		.WIDTH (VEC_W),
		.DEPTH (MAX_BONDS)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	vgut_back #(
		.MAX_BONDS(MAX_BONDS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_stat (q_stat),
		.head   (head),
		.pop    (pop),
		.re     (re),
		.raddr  (raddr),
		.rdata  (rdata),
		.result (result)
	);

endmodule

FILE: rtl/vgut_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vgut_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/vgut_cmd_fifo.sv
// Short command queue between the front and the dot product engine.
module vgut_cmd_fifo import vgut_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cmd_t       push_cmd,
	input  logic       pop,
	output cmd_t       head,
	output fifo_stat_t stat
);

	cmd_t               mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + FIFO_CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - FIFO_CW'(1);
			end
		end
	end

endmodule

FILE: rtl/vgut_front.sv
// Front end: accepts bond vectors, stores those below capacity and queues one command each.
module vgut_front import vgut_pkg::*; #(
	parameter int MAX_BONDS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	vgut_bond_if.sink                    bond,
	input  fifo_stat_t                   q_stat,
	output logic                         push,
	output cmd_t                         push_cmd,
	output logic                         we,
	output logic [$clog2(MAX_BONDS)-1:0] waddr,
	output logic [VEC_W-1:0]             wdata
);

	localparam int AW = $clog2(MAX_BONDS);
	localparam int CW = $clog2(MAX_BONDS + 1);

	logic [CW-1:0] count_q;
	logic          drain_q;
	logic          accept;
	logic          at_cap;

	// hold input while the queue is full, and after a polymer ends until the engine has read all its entries
	assign bond.ready = !q_stat.full && !(drain_q && !q_stat.empty);
	assign accept     = bond.valid && bond.ready;
	assign at_cap     = (count_q == CW'(MAX_BONDS));

	// classify and queue
	assign push         = accept;
	assign push_cmd.x   = bond.bond_x;
	assign push_cmd.y   = bond.bond_y;
	assign push_cmd.z   = bond.bond_z;
	assign push_cmd.col = at_cap ? '0 : IDX_W'(count_q);
	assign push_cmd.ovf = at_cap;

	// store the vector at the next free slot
	assign we    = accept && !at_cap;
	assign waddr = count_q[AW-1:0];
	assign wdata = {bond.bond_x, bond.bond_y, bond.bond_z};

	// track vector count and end of polymer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			drain_q <= 1'b0;
		end else begin
			if (accept) begin
				if (bond.last_bond) begin
					count_q <= '0;
				end else if (!at_cap) begin
					count_q <= count_q + CW'(1);
				end
			end
			if (accept && bond.last_bond) begin
				drain_q <= 1'b1;
			end else if (q_stat.empty) begin
				drain_q <= 1'b0;
			end
		end
	end

endmodule

FILE: rtl/vgut_back.sv
// Dot product engine: one stored vector per cycle against the queued vector while the output is not stalled.
module vgut_back import vgut_pkg::*; #(
	parameter int MAX_BONDS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fifo_stat_t                   q_stat,
	input  cmd_t                         head,
	output logic                         pop,
	output logic                         re,
	output logic [$clog2(MAX_BONDS)-1:0] raddr,
	input  logic [VEC_W-1:0]             rdata,
	vgut_result_if.source                result
);

	localparam int AW = $clog2(MAX_BONDS);

	logic             en;
	logic             issue;
	logic             issue_last;
	logic [IDX_W-1:0] row_q;

	logic             v_s1;
	logic [IDX_W-1:0] row_s1;
	logic [IDX_W-1:0] col_s1;
	logic             last_s1;
	logic             ovf_s1;
	cmd_t             cur_s1;

	logic                     v_s2;
	logic [IDX_W-1:0]         row_s2;
	logic [IDX_W-1:0]         col_s2;
	logic                     last_s2;
	logic                     ovf_s2;
	logic signed [PROD_W-1:0] px_s2;
	logic signed [PROD_W-1:0] py_s2;
	logic signed [PROD_W-1:0] pz_s2;

	logic signed [COORD_W-1:0] rx;
	logic signed [COORD_W-1:0] ry;
	logic signed [COORD_W-1:0] rz;
	logic signed [PROD_W-1:0]  mx;
	logic signed [PROD_W-1:0]  my;
	logic signed [PROD_W-1:0]  mz;
	logic signed [DOT_W-1:0]   sum;

	logic                    res_valid_q;
	logic [IDX_W-1:0]        res_row_q;
	logic [IDX_W-1:0]        res_col_q;
	logic signed [DOT_W-1:0] res_dot_q;
	logic                    res_last_q;
	logic                    res_ovf_q;

	// whole pipeline advances when the output register is free or drains
	assign en         = !res_valid_q || result.ready;
	assign issue      = en && !q_stat.empty;
	assign issue_last = head.ovf || (row_q == head.col);
	assign pop        = issue && issue_last;
	assign re         = en;
	assign raddr      = row_q[AW-1:0];

	// step through rows of the current column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
		end else if (issue) begin
			row_q <= issue_last ? '0 : row_q + IDX_W'(1);
		end
	end

	// stage 1: read data arrives, tags travel alongside
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1  <= head.ovf ? '0 : row_q;
			col_s1  <= head.col;
			last_s1 <= issue_last;
			ovf_s1  <= head.ovf;
			cur_s1  <= head;
		end
	end

	// stage 2: three component products
	assign rx = rdata[VEC_W-1 -: COORD_W];
	assign ry = rdata[2*COORD_W-1 -: COORD_W];
	assign rz = rdata[COORD_W-1:0];
	assign mx = rx * cur_s1.x;
	assign my = ry * cur_s1.y;
	assign mz = rz * cur_s1.z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			last_s2 <= last_s1;
			ovf_s2  <= ovf_s1;
			px_s2   <= mx;
			py_s2   <= my;
			pz_s2   <= mz;
		end
	end

	// stage 3: sum into the output register, zero for a dropped vector
	assign sum = DOT_W'(px_s2) + DOT_W'(py_s2) + DOT_W'(pz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_row_q  <= row_s2;
			res_col_q  <= col_s2;
			res_dot_q  <= ovf_s2 ? '0 : sum;
			res_last_q <= last_s2;
			res_ovf_q  <= ovf_s2;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.row_index   = res_row_q;
	assign result.col_index   = res_col_q;
	assign result.pair_dot    = res_dot_q;
	assign result.last_result = res_last_q;
	assign result.overflow    = res_ovf_q;

endmodule

FILE: test/vector_gram_upper_triangle_tb.sv
// Self-checking testbench of the bond vector Gram matrix upper triangle block.
module vector_gram_upper_triangle_tb;
	import vgut_pkg::*;

	localparam int BOND_CAP     = 64;
	localparam int RANDOM_ITEMS = 80;
	localparam int TAIL_CYCLES  = 40;
	localparam int CYCLE_LIMIT  = 500000;

	localparam logic signed [COORD_W-1:0] C_MIN = 16'sh8000;
	localparam logic signed [COORD_W-1:0] C_MAX = 16'sh7FFF;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      last;
	} bond_t;

	typedef struct packed {
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [DOT_W-1:0] dot;
		logic                    last;
		logic                    ovf;
	} gram_entry_t;

	// one directed vector; typed rows carry the single product they must give
	typedef struct {
		bond_t                   vec;
		bit                      typed;
		logic signed [DOT_W-1:0] dot;
	} directed_row_t;

	logic clk;
	logic arst_n;

	vgut_bond_if   bond_ch ();
	vgut_result_if result_ch ();

	vector_gram_upper_triangle #(
		.MAX_BONDS(BOND_CAP)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.bond   (bond_ch),
		.result (result_ch)
	);

	// typed rows open a fresh polymer and close it at once, so each gives one self product
	directed_row_t directed_rows [18] = '{
		'{'{C_MIN, C_MIN, C_MIN, 1'b1}, 1'b1, 33'sd3221225472},
		'{'{C_MAX, C_MAX, C_MAX, 1'b1}, 1'b1, 33'sd3221028867},
		'{'{16'sd0, 16'sd0, 16'sd0, 1'b1}, 1'b1, 33'sd0},
		'{'{C_MIN, C_MAX, 16'sd0, 1'b1}, 1'b1, 33'sd2147418113},
		'{'{16'sd1, 16'sd0, 16'sd0, 1'b1}, 1'b1, 33'sd1},
		'{'{-16'sd1, -16'sd1, -16'sd1, 1'b1}, 1'b1, 33'sd3},
		'{'{C_MAX, C_MAX, C_MAX, 1'b0}, 1'b0, '0},
		'{'{C_MIN, C_MIN, C_MIN, 1'b0}, 1'b0, '0},
		'{'{C_MIN, C_MIN, C_MIN, 1'b0}, 1'b0, '0},
		'{'{16'sd0, -16'sd1, 16'sd1, 1'b0}, 1'b0, '0},
		'{'{C_MAX, C_MIN, C_MAX, 1'b1}, 1'b0, '0},
		'{'{16'sh1234, -16'sh0567, 16'sh0F0F, 1'b0}, 1'b0, '0},
		'{'{16'sh5555, 16'sh2AAA, -16'sh5555, 1'b0}, 1'b0, '0},
		'{'{-16'sd4096, 16'sd4096, -16'sd4096, 1'b0}, 1'b0, '0},
		'{'{16'sd4096, 16'sd4096, 16'sd4096, 1'b0}, 1'b0, '0},
		'{'{16'sd0, 16'sd0, C_MIN, 1'b0}, 1'b0, '0},
		'{'{C_MIN, 16'sd0, 16'sd0, 1'b1}, 1'b0, '0},
		'{'{16'sh7000, 16'sh0100, -16'sd2, 1'b0}, 1'b0, '0}
	};

	bond_t       bond_mem [BOND_CAP];
	int          stored_count = 0;
	gram_entry_t pending_products [$];

	int          errors          = 0;
	int          vectors_sent    = 0;
	int          results_checked = 0;
	int          overflow_seen   = 0;
	int          polymers_closed = 0;
	int unsigned cycles          = 0;
	bit          bond_burst      = 1'b0;
	bit          result_burst    = 1'b0;

	// free-running clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d products outstanding", $time, cycles,
				pending_products.size());
			$display("vector_gram_upper_triangle_tb NOT OK");
			$finish;
		end
	end

	function automatic logic signed [DOT_W-1:0] bond_dot(bond_t a, bond_t b);
		longint acc;
		acc = longint'(a.x) * longint'(b.x) + longint'(a.y) * longint'(b.y)
			+ longint'(a.z) * longint'(b.z);
		return acc[DOT_W-1:0];
	endfunction

	// store the vector and queue its column of the Gram matrix; keep = 0 only updates state
	function automatic void gram_column(bond_t b, bit keep);
		gram_entry_t e;
		if (stored_count >= BOND_CAP) begin
			e = '{row: '0, col: '0, dot: '0, last: 1'b1, ovf: 1'b1};
			if (keep)
				pending_products.push_back(e);
		end else begin
			bond_mem[stored_count] = b;
			for (int i = 0; i <= stored_count; i++) begin
				e = '{row: IDX_W'(i), col: IDX_W'(stored_count),
					dot: bond_dot(bond_mem[i], b), last: (i == stored_count), ovf: 1'b0};
				if (keep)
					pending_products.push_back(e);
			end
			stored_count++;
		end
		if (b.last) begin
			stored_count = 0;
			polymers_closed++;
		end
	endfunction

	function automatic void field_check(string name, logic signed [63:0] want,
			logic signed [63:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endfunction

	function automatic void check_product();
		gram_entry_t got;
		gram_entry_t want;
		got = '{row: result_ch.row_index, col: result_ch.col_index,
			dot: result_ch.pair_dot, last: result_ch.last_result, ovf: result_ch.overflow};
		results_checked++;
		if (got.ovf === 1'b1)
			overflow_seen++;
		if (pending_products.size() == 0) begin
			errors++;
			$display("%0t: unexpected result, expected none, actual row %0d col %0d dot %0d",
				$time, got.row, got.col, got.dot);
		end else begin
			want = pending_products.pop_front();
			field_check("row_index", want.row, got.row);
			field_check("col_index", want.col, got.col);
			field_check("pair_dot", want.dot, got.dot);
			field_check("last_result", want.last, got.last);
			field_check("overflow", want.ovf, got.ovf);
		end
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 7))
			0: return C_MIN;
			1: return C_MAX;
			2: return COORD_W'($signed($urandom_range(0, 16)) - 8);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	function automatic bond_t make_bond(logic last);
		bond_t b;
		b.x = rand_coord();
		b.y = rand_coord();
		b.z = rand_coord();
		b.last = last;
		return b;
	endfunction

	// offer one vector after a random gap and predict its column once it transfers
	task automatic send_bond(bond_t b, bit typed, logic signed [DOT_W-1:0] typed_dot);
		int gap;
		gram_entry_t e;
		gap = bond_burst ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			bond_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bond_ch.valid     <= 1'b1;
		bond_ch.bond_x    <= b.x;
		bond_ch.bond_y    <= b.y;
		bond_ch.bond_z    <= b.z;
		bond_ch.last_bond <= b.last;
		do @(posedge clk); while (bond_ch.ready !== 1'b1);
		vectors_sent++;
		if (typed) begin
			gram_column(b, 1'b0);
			e = '{row: '0, col: '0, dot: typed_dot, last: 1'b1, ovf: 1'b0};
			pending_products.push_back(e);
		end else begin
			gram_column(b, 1'b1);
		end
	endtask

	// hold the sender until every queued product has come out
	task automatic hold_until_drained();
		bond_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_products.size() != 0) @(posedge clk);
	endtask

	// result side: take a transfer, then, outside a burst, stall for a random number of cycles
	initial begin : result_drain
		int gap;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		result_ch.ready <= 1'b1;
		forever begin
			do @(posedge clk); while (!(result_ch.valid === 1'b1 && result_ch.ready === 1'b1));
			check_product();
			gap = result_burst ? 0 : $urandom_range(0, 10);
			if (gap != 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				result_ch.ready <= 1'b1;
			end
		end
	end

	// stimulus: directed table, then random polymers with one filled past capacity
	initial begin : stimulus
		int random_sent;
		int polymer_no;
		int len;
		int extra;
		bit long_done;
		bond_ch.valid     = 1'b0;
		bond_ch.bond_x    = '0;
		bond_ch.bond_y    = '0;
		bond_ch.bond_z    = '0;
		bond_ch.last_bond = 1'b0;
		arst_n            = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			send_bond(directed_rows[k].vec, directed_rows[k].typed, directed_rows[k].dot);

		hold_until_drained();

		random_sent = 0;
		polymer_no  = 0;
		long_done   = 1'b0;
		while (random_sent < RANDOM_ITEMS || !long_done) begin
			bond_burst   = ($urandom_range(0, 3) == 0);
			result_burst = ($urandom_range(0, 3) == 0);
			if (!long_done && polymer_no == 3) begin
				// fill to capacity, then drop one to three vectors; the last dropped one closes
				extra = $urandom_range(1, 3);
				while (stored_count < BOND_CAP) begin
					send_bond(make_bond(1'b0), 1'b0, '0);
					random_sent++;
				end
				for (int k = 1; k <= extra; k++) begin
					send_bond(make_bond(k == extra), 1'b0, '0);
					random_sent++;
				end
				long_done = 1'b1;
			end else begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
				for (int k = 1; k <= len; k++) begin
					send_bond(make_bond(k == len), 1'b0, '0);
					random_sent++;
				end
			end
			polymer_no++;
			if ($urandom_range(0, 5) == 0)
				hold_until_drained();
		end

		// drain, then watch for stray results
		bond_ch.valid <= 1'b0;
		while (pending_products.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("%0d bond vectors in %0d polymers, %0d products checked (%0d overflow)",
			vectors_sent, polymers_closed, results_checked, overflow_seen);
		$display("field extremes, full capacity with dropped vectors, %0d mismatches", errors);
		if (errors == 0)
			$display("vector_gram_upper_triangle_tb OK");
		else
			$display("vector_gram_upper_triangle_tb NOT OK");
		$finish;
	end

endmodule
